// ===== rtl/cle_pkg.sv =====
// Shared types, codes and default sizes for the circular list engine.
package cle_pkg;

    // Default sizes handed to the top-level parameters
    localparam int CLE_CAPACITY   = 16;
    localparam int CLE_DATA_WIDTH = 32;

    // Fixed field widths of the transaction ports
    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Operation codes
    localparam logic [OP_W-1:0] OP_ADD_FIRST = 3'd0;
    localparam logic [OP_W-1:0] OP_ADD_LAST  = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD_AT    = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_FIRST = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_LAST  = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_AT    = 3'd5;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd3;

    // Port enables from the sequencer to the slot store
    typedef struct packed {
        logic link_rd;
        logic link_wr;
        logic val_rd;
        logic val_wr;
    } mem_ctl_t;

endpackage

// ===== rtl/cle_store.sv =====
// Slot store: link memory and value memory, one write and one registered read each.
module cle_store
    import cle_pkg::*;
#(
    parameter int CAPACITY   = CLE_CAPACITY,
    parameter int DATA_WIDTH = CLE_DATA_WIDTH,
    localparam int SLOT_W    = $clog2(CAPACITY)
) (
    input  logic                         aclk,
    input  mem_ctl_t                     ctl,
    input  logic [SLOT_W-1:0]            link_raddr,
    input  logic [SLOT_W-1:0]            link_waddr,
    input  logic [SLOT_W-1:0]            link_wdata,
    output logic [SLOT_W-1:0]            link_rdata,
    input  logic [SLOT_W-1:0]            val_raddr,
    input  logic [SLOT_W-1:0]            val_waddr,
    input  logic signed [DATA_WIDTH-1:0] val_wdata,
    output logic signed [DATA_WIDTH-1:0] val_rdata
);

    logic [SLOT_W-1:0]            link_mem [CAPACITY];
    logic signed [DATA_WIDTH-1:0] val_mem  [CAPACITY];

    // Link memory: write port and registered read port
    always_ff @(posedge aclk) begin
        if (ctl.link_wr) begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (ctl.link_rd) begin
            link_rdata <= link_mem[link_raddr];
        end
    end

    // Value memory: write port and registered read port
    always_ff @(posedge aclk) begin
        if (ctl.val_wr) begin
            val_mem[val_waddr] <= val_wdata;
        end
        if (ctl.val_rd) begin
            val_rdata <= val_mem[val_raddr];
        end
    end

endmodule

// ===== rtl/circular_list_engine_core.sv =====
// Circular list engine top level: operation sequencer, link walker and result register.
//
//   channel   ports                                         direction
//   s_        s_valid s_ready s_operation s_position s_value  request in
//   m_        m_valid m_ready m_status m_removed_value
//             m_element_count                               result out
//
// The duration of a transaction is set by the link walk, which follows one link of the
// slot link memory per cycle (positional add/delete and delete last); status-only
// answers skip the walk.
// Reset (aresetn low, synchronous) empties the list; slot memories are not cleared.
// s_ready is high only while the sequencer is idle; a finished result waits in the
// output register, so the next request can enter while m_ready is held low.
module circular_list_engine_core
    import cle_pkg::*;
#(
    parameter int CAPACITY   = CLE_CAPACITY,
    parameter int DATA_WIDTH = CLE_DATA_WIDTH
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [OP_W-1:0]            s_operation,
    input  logic [POS_W-1:0]           s_position,
    input  logic signed [VALUE_W-1:0]  s_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [STATUS_W-1:0]        m_status,
    output logic signed [VALUE_W-1:0]  m_removed_value,
    output logic [COUNT_W-1:0]         m_element_count
);

    localparam int SLOT_W = $clog2(CAPACITY);
    localparam int LEN_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = (LEN_W + 1 > POS_W) ? LEN_W + 1 : POS_W;
    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

    typedef enum logic [13:0] {
        S_IDLE     = 14'b00000000000001,
        S_DECODE   = 14'b00000000000010,
        S_ALLOC    = 14'b00000000000100,
        S_END_LINK = 14'b00000000001000,
        S_END_TAIL = 14'b00000000010000,
        S_WALK     = 14'b00000000100000,
        S_ADD_W1   = 14'b00000001000000,
        S_ADD_W2   = 14'b00000010000000,
        S_DF_RD    = 14'b00000100000000,
        S_DF_W     = 14'b00001000000000,
        S_DL_W     = 14'b00010000000000,
        S_DM_RD    = 14'b00100000000000,
        S_DM_W     = 14'b01000000000000,
        S_DONE     = 14'b10000000000000
    } state_t;

    typedef enum logic [2:0] {
        PLAN_NONE,
        PLAN_ADD_FIRST,
        PLAN_ADD_LAST,
        PLAN_ADD_MID,
        PLAN_DEL_FIRST,
        PLAN_DEL_LAST,
        PLAN_DEL_MID
    } plan_t;

    // Control registers
    state_t                state_reg, state_next;
    logic [LEN_W-1:0]      len_reg, len_next;
    logic [LEN_W-1:0]      wm_reg, wm_next;
    logic [SLOT_W-1:0]     free_head_reg, free_head_next;
    logic [SLOT_W-1:0]     head_reg, head_next;
    logic [SLOT_W-1:0]     tail_reg, tail_next;
    logic                  m_valid_reg, m_valid_next;

    // Working registers
    logic [OP_W-1:0]       op_reg, op_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic signed [VALUE_W-1:0] value_reg, value_next;
    plan_t                 plan_reg, plan_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [SLOT_W-1:0]     new_slot_reg, new_slot_next;
    logic [SLOT_W-1:0]     slot_a_reg, slot_a_next;
    logic [SLOT_W-1:0]     victim_reg, victim_next;
    logic [LEN_W-1:0]      walk_cnt_reg, walk_cnt_next;
    logic                  walk_fresh_reg, walk_fresh_next;
    logic [STATUS_W-1:0]   m_status_reg, m_status_next;
    logic signed [VALUE_W-1:0] m_removed_reg, m_removed_next;
    logic [COUNT_W-1:0]    m_count_reg, m_count_next;

    // Store interface
    mem_ctl_t                     ctl;
    logic [SLOT_W-1:0]            link_raddr, link_waddr, link_wdata, link_rdata;
    logic [SLOT_W-1:0]            val_raddr, val_waddr;
    logic signed [DATA_WIDTH-1:0] val_wdata, val_rdata;

    // Decode helpers
    logic [CMP_W-1:0]  pos_c, len_c, len_p1;
    logic              is_add, is_del, from_free;
    plan_t             plan_d;
    logic [STATUS_W-1:0] status_d;
    logic [SLOT_W-1:0] walk_cur;

    cle_store #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .aclk       (aclk),
        .ctl        (ctl),
        .link_raddr (link_raddr),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .link_rdata (link_rdata),
        .val_raddr  (val_raddr),
        .val_waddr  (val_waddr),
        .val_wdata  (val_wdata),
        .val_rdata  (val_rdata)
    );

    assign s_ready         = (state_reg == S_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_removed_value = m_removed_reg;
    assign m_element_count = m_count_reg;

    // Classify the held request against the current list
    assign pos_c     = CMP_W'(pos_reg);
    assign len_c     = CMP_W'(len_reg);
    assign len_p1    = len_c + CMP_W'(1);
    assign is_add    = (op_reg == OP_ADD_FIRST) || (op_reg == OP_ADD_LAST)
                       || (op_reg == OP_ADD_AT);
    assign is_del    = (op_reg == OP_DEL_FIRST) || (op_reg == OP_DEL_LAST)
                       || (op_reg == OP_DEL_AT);
    assign from_free = (wm_reg != len_reg);
    assign walk_cur  = walk_fresh_reg ? link_rdata : slot_a_reg;

    always_comb begin
        plan_d   = PLAN_NONE;
        status_d = ST_OK;
        if (is_add) begin
            if (len_reg >= CAP_LEN) begin
                status_d = ST_FULL;
            end else if ((op_reg == OP_ADD_FIRST)
                         || ((op_reg == OP_ADD_AT)
                             && ((len_c == '0) || (pos_c == CMP_W'(1))))) begin
                plan_d = PLAN_ADD_FIRST;
            end else if ((op_reg == OP_ADD_LAST) || (pos_c == len_p1)) begin
                plan_d = PLAN_ADD_LAST;
            end else if ((pos_c == '0) || (pos_c > len_p1)) begin
                status_d = ST_INVALID;
            end else begin
                plan_d = PLAN_ADD_MID;
            end
        end else if (is_del) begin
            if (len_reg == '0) begin
                status_d = ST_EMPTY;
            end else if ((op_reg == OP_DEL_FIRST)
                         || ((op_reg == OP_DEL_AT) && (pos_c == CMP_W'(1)))) begin
                plan_d = PLAN_DEL_FIRST;
            end else if ((op_reg == OP_DEL_LAST)
                         || ((pos_c == len_c) && (pos_c != '0))) begin
                plan_d = PLAN_DEL_LAST;
            end else if ((pos_c == '0) || (pos_c > len_c)) begin
                status_d = ST_INVALID;
            end else begin
                plan_d = PLAN_DEL_MID;
            end
        end else begin
            status_d = ST_INVALID;
        end
    end

    // Sequencer: next state, store commands and list pointer updates
    always_comb begin
        state_next      = state_reg;
        len_next        = len_reg;
        wm_next         = wm_reg;
        free_head_next  = free_head_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        m_valid_next    = m_valid_reg;
        op_next         = op_reg;
        pos_next        = pos_reg;
        value_next      = value_reg;
        plan_next       = plan_reg;
        status_next     = status_reg;
        new_slot_next   = new_slot_reg;
        slot_a_next     = slot_a_reg;
        victim_next     = victim_reg;
        walk_cnt_next   = walk_cnt_reg;
        walk_fresh_next = walk_fresh_reg;
        m_status_next   = m_status_reg;
        m_removed_next  = m_removed_reg;
        m_count_next    = m_count_reg;

        ctl        = '0;
        link_raddr = slot_a_reg;
        link_waddr = new_slot_reg;
        link_wdata = head_reg;
        val_raddr  = victim_reg;
        val_waddr  = new_slot_reg;
        val_wdata  = DATA_WIDTH'(value_reg);

        // Drop the result once the sink takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next    = s_operation;
                    pos_next   = s_position;
                    value_next = s_value;
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                plan_next     = plan_d;
                status_next   = status_d;
                new_slot_next = from_free ? free_head_reg : SLOT_W'(wm_reg);
                // Fetch the next free-list entry in case the add pops it
                ctl.link_rd   = 1'b1;
                link_raddr    = free_head_reg;
                unique case (plan_d)
                    PLAN_ADD_FIRST, PLAN_ADD_LAST, PLAN_ADD_MID: begin
                        ctl.val_wr = 1'b1;
                        val_waddr  = from_free ? free_head_reg : SLOT_W'(wm_reg);
                        state_next = S_ALLOC;
                    end
                    PLAN_DEL_FIRST: begin
                        victim_next = head_reg;
                        state_next  = (len_reg > LEN_W'(1)) ? S_DF_RD : S_DM_W;
                    end
                    PLAN_DEL_LAST: begin
                        victim_next     = tail_reg;
                        slot_a_next     = head_reg;
                        walk_fresh_next = 1'b0;
                        walk_cnt_next   = len_reg - LEN_W'(2);
                        state_next      = (len_reg > LEN_W'(1)) ? S_WALK : S_DM_W;
                    end
                    PLAN_DEL_MID: begin
                        slot_a_next     = head_reg;
                        walk_fresh_next = 1'b0;
                        walk_cnt_next   = LEN_W'(pos_c - CMP_W'(2));
                        state_next      = S_WALK;
                    end
                    default: begin
                        state_next = S_DONE;
                    end
                endcase
            end
            S_ALLOC: begin
                // Pop the free list, or advance the never-used watermark
                if (from_free) begin
                    free_head_next = link_rdata;
                end else begin
                    wm_next = wm_reg + LEN_W'(1);
                end
                if (plan_reg == PLAN_ADD_MID) begin
                    slot_a_next     = head_reg;
                    walk_fresh_next = 1'b0;
                    walk_cnt_next   = LEN_W'(pos_c - CMP_W'(2));
                    state_next      = S_WALK;
                end else begin
                    state_next = S_END_LINK;
                end
            end
            S_END_LINK: begin
                ctl.link_wr = 1'b1;
                link_waddr  = new_slot_reg;
                if (len_reg == '0) begin
                    link_wdata = new_slot_reg;
                    head_next  = new_slot_reg;
                    tail_next  = new_slot_reg;
                    len_next   = len_reg + LEN_W'(1);
                    state_next = S_DONE;
                end else begin
                    link_wdata = head_reg;
                    state_next = S_END_TAIL;
                end
            end
            S_END_TAIL: begin
                ctl.link_wr = 1'b1;
                link_waddr  = tail_reg;
                link_wdata  = new_slot_reg;
                if (plan_reg == PLAN_ADD_FIRST) begin
                    head_next = new_slot_reg;
                end else begin
                    tail_next = new_slot_reg;
                end
                len_next   = len_reg + LEN_W'(1);
                state_next = S_DONE;
            end
            S_WALK: begin
                // Follow one link per cycle; at the end fetch the target's link
                ctl.link_rd = 1'b1;
                link_raddr  = walk_cur;
                slot_a_next = walk_cur;
                if (walk_cnt_reg == '0) begin
                    walk_fresh_next = 1'b0;
                    if (plan_reg == PLAN_ADD_MID) begin
                        state_next = S_ADD_W1;
                    end else if (plan_reg == PLAN_DEL_MID) begin
                        state_next = S_DM_RD;
                    end else begin
                        state_next = S_DL_W;
                    end
                end else begin
                    walk_fresh_next = 1'b1;
                    walk_cnt_next   = walk_cnt_reg - LEN_W'(1);
                end
            end
            S_ADD_W1: begin
                ctl.link_wr = 1'b1;
                link_waddr  = new_slot_reg;
                link_wdata  = link_rdata;
                state_next  = S_ADD_W2;
            end
            S_ADD_W2: begin
                ctl.link_wr = 1'b1;
                link_waddr  = slot_a_reg;
                link_wdata  = new_slot_reg;
                len_next    = len_reg + LEN_W'(1);
                state_next  = S_DONE;
            end
            S_DF_RD: begin
                ctl.link_rd = 1'b1;
                link_raddr  = head_reg;
                state_next  = S_DF_W;
            end
            S_DF_W: begin
                ctl.link_wr = 1'b1;
                link_waddr  = tail_reg;
                link_wdata  = link_rdata;
                head_next   = link_rdata;
                slot_a_next = victim_reg;
                state_next  = S_DM_W;
                plan_next   = PLAN_DEL_FIRST;
            end
            S_DL_W: begin
                ctl.link_wr = 1'b1;
                link_waddr  = slot_a_reg;
                link_wdata  = head_reg;
                tail_next   = slot_a_reg;
                state_next  = S_DM_W;
            end
            S_DM_RD: begin
                victim_next = link_rdata;
                ctl.link_rd = 1'b1;
                link_raddr  = link_rdata;
                state_next  = S_DM_W;
            end
            S_DM_W: begin
                // Unlink a middle victim, then release the victim slot
                if (plan_reg == PLAN_DEL_MID) begin
                    ctl.link_wr = 1'b1;
                    link_waddr  = slot_a_reg;
                    link_wdata  = link_rdata;
                    state_next  = S_DM_W;
                    plan_next   = PLAN_DEL_FIRST;
                end else begin
                    // Release: return the slot to the free list and fetch its data
                    ctl.link_wr    = 1'b1;
                    link_waddr     = victim_reg;
                    link_wdata     = free_head_reg;
                    free_head_next = victim_reg;
                    ctl.val_rd     = 1'b1;
                    val_raddr      = victim_reg;
                    len_next       = len_reg - LEN_W'(1);
                    if (len_reg == LEN_W'(1)) begin
                        head_next = '0;
                        tail_next = '0;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                // Load the result once the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_count_next  = COUNT_W'(len_reg);
                    if ((status_reg == ST_OK)
                        && ((plan_reg == PLAN_DEL_FIRST) || (plan_reg == PLAN_DEL_LAST)
                            || (plan_reg == PLAN_DEL_MID))) begin
                        m_removed_next = VALUE_W'(val_rdata);
                    end else begin
                        m_removed_next = '0;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state under reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            len_reg       <= '0;
            wm_reg        <= '0;
            free_head_reg <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            wm_reg        <= wm_next;
            free_head_reg <= free_head_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Advance working and result payload registers
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        pos_reg        <= pos_next;
        value_reg      <= value_next;
        plan_reg       <= plan_next;
        status_reg     <= status_next;
        new_slot_reg   <= new_slot_next;
        slot_a_reg     <= slot_a_next;
        victim_reg     <= victim_next;
        walk_cnt_reg   <= walk_cnt_next;
        walk_fresh_reg <= walk_fresh_next;
        m_status_reg   <= m_status_next;
        m_removed_reg  <= m_removed_next;
        m_count_reg    <= m_count_next;
    end

`ifndef NO_ASSERTIONS
    // A request closes the input side until its sequence is done
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted again while sequencing");

    // Slots handed out never fall below slots in the list
    assert property (@(posedge aclk) disable iff (!aresetn)
        wm_reg >= len_reg)
        else $error("watermark below list length");

    // A walk never needs more steps than the list has links
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_WALK) |-> (walk_cnt_reg < len_reg))
        else $error("link walk overruns the list");

    // A result appears only out of the finishing step
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the finishing step");

    // The count moves by one element at most per transaction
    assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && (len_reg != $past(len_reg))
        |-> (len_reg == $past(len_reg) + LEN_W'(1))
            || (len_reg == $past(len_reg) - LEN_W'(1)))
        else $error("list length jumped");
`endif

endmodule
